>>> hdl/rts_pkg.sv
// shared types and constants for the real-time task selector
`default_nettype none
package rts_pkg;

  localparam int MAX_TASKS = 256;
  localparam int TICK_BITS = 32;
  localparam int FIELD_BITS = 32;
  localparam int IDENT_BITS = 8;
  localparam int POSITION_BITS = 8;
  localparam int POLICY_BITS = 3;
  // entry counter must be able to hold MAX_TASKS itself
  localparam int COUNT_BITS = $clog2(MAX_TASKS + 1);

  typedef enum logic [POLICY_BITS-1:0] {
    POL_RM  = 3'd0,
    POL_DM  = 3'd1,
    POL_EDF = 3'd2,
    POL_LLF = 3'd3,
    POL_SRT = 3'd4
  } policy_t;

  typedef logic [TICK_BITS-1:0] key_t;

  // one table entry after key selection
  typedef struct packed {
    logic                  eligible;
    key_t                  key;
    logic [IDENT_BITS-1:0] ident;
    logic                  by_ident;
    logic                  last;
  } entry_t;

endpackage
`default_nettype wire

>>> hdl/rts_key.sv
// input register stage: eligibility and policy key for each table entry
`default_nettype none
module rts_key (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic [rts_pkg::POLICY_BITS-1:0]        policy,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   ready_req,
  input  wire logic [rts_pkg::FIELD_BITS-1:0]         remaining_work,
  input  wire logic [rts_pkg::FIELD_BITS-1:0]         task_period,
  input  wire logic [rts_pkg::FIELD_BITS-1:0]         relative_deadline,
  input  wire logic [rts_pkg::FIELD_BITS-1:0]         absolute_deadline,
  input  wire logic [rts_pkg::IDENT_BITS-1:0]         task_ident,
  input  wire logic [rts_pkg::FIELD_BITS-1:0]         current_tick,
  input  wire logic                                   last_entry,
  input  wire logic                                   advance,
  output logic                                        stage_valid,
  output rts_pkg::entry_t                             stage
);

  rts_pkg::key_t   rem;
  rts_pkg::key_t   lax;
  rts_pkg::key_t   key_next;
  rts_pkg::entry_t stage_next;

  assign rem = remaining_work[rts_pkg::TICK_BITS-1:0];
  assign lax = absolute_deadline[rts_pkg::TICK_BITS-1:0]
             - current_tick[rts_pkg::TICK_BITS-1:0] - rem;

  always_comb begin
    unique case (policy)
      rts_pkg::POL_DM:  key_next = relative_deadline[rts_pkg::TICK_BITS-1:0];
      rts_pkg::POL_EDF: key_next = absolute_deadline[rts_pkg::TICK_BITS-1:0];
      // flip the sign bit so signed laxity orders as unsigned
      rts_pkg::POL_LLF: key_next = {~lax[rts_pkg::TICK_BITS-1], lax[rts_pkg::TICK_BITS-2:0]};
      rts_pkg::POL_SRT: key_next = rem;
      default:          key_next = task_period[rts_pkg::TICK_BITS-1:0];
    endcase
  end

  always_comb begin
    stage_next.eligible = ready_req && (rem != '0);
    stage_next.key      = key_next;
    stage_next.ident    = task_ident;
    stage_next.by_ident = (policy != rts_pkg::POL_SRT);
    stage_next.last     = last_entry;
  end

  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage <= stage_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/rts_scan.sv
// running best over the table and the result register
`default_nettype none
module rts_scan (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                stage_valid,
  input  wire rts_pkg::entry_t                     stage,
  output logic                                     advance,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     found,
  output logic [rts_pkg::POSITION_BITS-1:0]        chosen_position
);

  logic [rts_pkg::COUNT_BITS-1:0]    entry_position;
  logic [rts_pkg::COUNT_BITS-1:0]    entry_position_next;
  logic                              have_best;
  logic                              have_best_next;
  logic [rts_pkg::POSITION_BITS-1:0] best_position;
  logic [rts_pkg::POSITION_BITS-1:0] best_position_next;
  rts_pkg::key_t                     top_key;
  rts_pkg::key_t                     top_key_next;
  logic [rts_pkg::IDENT_BITS-1:0]    best_ident;
  logic [rts_pkg::IDENT_BITS-1:0]    best_ident_next;
  logic                              in_range;
  logic                              take;
  logic                              step;

  // a last entry cannot move on while the previous result is still waiting
  assign advance = !(stage_valid && stage.last && out_valid && !out_ready);
  assign step = stage_valid && advance;

  assign in_range = (entry_position < rts_pkg::COUNT_BITS'(rts_pkg::MAX_TASKS));
  assign take = in_range && stage.eligible &&
                (!have_best || (stage.key < top_key) ||
                 ((stage.key == top_key) && stage.by_ident && (stage.ident < best_ident)));

  always_comb begin
    have_best_next      = have_best;
    best_position_next  = best_position;
    top_key_next        = top_key;
    best_ident_next     = best_ident;
    entry_position_next = entry_position;
    if (take) begin
      have_best_next     = 1'b1;
      best_position_next = entry_position[rts_pkg::POSITION_BITS-1:0];
      top_key_next       = stage.key;
      best_ident_next    = stage.ident;
    end
    if (in_range) begin
      entry_position_next = entry_position + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_position <= '0;
      have_best      <= 1'b0;
      best_position  <= '0;
      top_key        <= '0;
      best_ident     <= '0;
    end else if (step) begin
      if (stage.last) begin
        entry_position <= '0;
        have_best      <= 1'b0;
        best_position  <= '0;
        top_key        <= '0;
        best_ident     <= '0;
      end else begin
        entry_position <= entry_position_next;
        have_best      <= have_best_next;
        best_position  <= best_position_next;
        top_key        <= top_key_next;
        best_ident     <= best_ident_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && stage.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && stage.last) begin
      found           <= have_best_next;
      chosen_position <= have_best_next ? best_position_next : '0;
    end
  end

endmodule
`default_nettype wire

>>> hdl/realtime_task_selector.sv
// top level of the real-time task selector
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+----------------------------------------
//   cfg      | cfg_valid / cfg_ready        | policy
//   in       | in_valid / in_ready          | ready_req .. last_entry, one table entry
//   out      | out_valid / out_ready        | found, chosen_position
//
// one table entry per cycle while the input is not stalled; the last entry of a table passes
// through the key register, then the running-best compare into the result register
// reset sets policy to rate monotonic and clears the scan state and both valids
// the input stalls only while a last entry waits behind a result not yet taken
// cfg_ready is always high
`default_nettype none
module realtime_task_selector (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rts_pkg::POLICY_BITS-1:0]     policy,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                ready_req,
  input  wire logic [rts_pkg::FIELD_BITS-1:0]      remaining_work,
  input  wire logic [rts_pkg::FIELD_BITS-1:0]      task_period,
  input  wire logic [rts_pkg::FIELD_BITS-1:0]      relative_deadline,
  input  wire logic [rts_pkg::FIELD_BITS-1:0]      absolute_deadline,
  input  wire logic [rts_pkg::IDENT_BITS-1:0]      task_ident,
  input  wire logic [rts_pkg::FIELD_BITS-1:0]      current_tick,
  input  wire logic                                last_entry,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     found,
  output logic [rts_pkg::POSITION_BITS-1:0]        chosen_position
);

  logic [rts_pkg::POLICY_BITS-1:0] policy_reg;
  logic                            stage_valid;
  rts_pkg::entry_t                 stage;
  logic                            advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_reg <= rts_pkg::POL_RM;
    end else if (cfg_valid && cfg_ready) begin
      policy_reg <= policy;
    end
  end

  rts_key u_key (
    .clk               (clk),
    .rst               (rst),
    .policy            (policy_reg),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .ready_req         (ready_req),
    .remaining_work    (remaining_work),
    .task_period       (task_period),
    .relative_deadline (relative_deadline),
    .absolute_deadline (absolute_deadline),
    .task_ident        (task_ident),
    .current_tick      (current_tick),
    .last_entry        (last_entry),
    .advance           (advance),
    .stage_valid       (stage_valid),
    .stage             (stage)
  );

  rts_scan u_scan (
    .clk             (clk),
    .rst             (rst),
    .stage_valid     (stage_valid),
    .stage           (stage),
    .advance         (advance),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .found           (found),
    .chosen_position (chosen_position)
  );

`ifndef ASSERT_OFF
  // input backpressure only comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready && stage_valid && stage.last))
    else $error("input stalled without a pending result");

  // no winner means position zero
  a_empty_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (chosen_position == '0))
    else $error("position nonzero with no task found");

  // a new result comes from a last entry held in the key register
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stage_valid && stage.last))
    else $error("result without a last entry");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && in_ready))
    else $error("valid state survived reset");
`endif

endmodule
`default_nettype wire
